// ===== hdl/cflts_pkg.sv =====
// Shared types and constants for the CFL time-step reduction block.
// Used by the controller, the datapath and the top level; depends on nothing.
package cflts_pkg;

    // Fixed-point format: inputs are Q(32-F).F, rates are Q(64-2F).2F.
    localparam int FRAC_BITS  = 16;
    localparam int RATE_SH    = 2 * FRAC_BITS;
    localparam int DIV_STEPS  = 64 + RATE_SH;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS + 1);
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS + 1);

    // Configuration register indexes.
    localparam logic [1:0] REG_DIM     = 2'd0;
    localparam logic [1:0] REG_GAMMA   = 2'd1;
    localparam logic [1:0] REG_COURANT = 2'd2;
    localparam logic [1:0] REG_SPACING = 2'd3;

    // Reset values of the configuration registers.
    localparam logic [1:0]  DIM_RESET     = 2'd3;
    localparam logic [31:0] GAMMA_RESET   = 32'd91750;
    localparam logic [31:0] COURANT_RESET = 32'd32768;
    localparam logic [31:0] SPACING_RESET = 32'd65536;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_GP,
        OP_DIV_C2,
        OP_SQRT,
        OP_DIV_R,
        OP_DIV_VX,
        OP_DIV_VY,
        OP_DIV_VZ,
        OP_UPDATE,
        OP_DIV_DT,
        OP_MUL_LO,
        OP_MUL_HI,
        OP_ACC,
        OP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   start;
        logic   take;
    } dp_cmd_t;

    typedef struct packed {
        logic       fluid;
        logic       last;
        logic [1:0] dim;
        logic       div_busy;
        logic       sqrt_busy;
        logic       out_full;
    } dp_stat_t;

endpackage

// ===== hdl/cflts_dp.sv =====
// Datapath of the CFL time-step reduction: configuration, operand capture,
// shared multiplier, restoring divider, square-root unit and result register.
// Depends on cflts_pkg.
module cflts_dp
    import cflts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic [255:0] in_data,
    input  logic         in_solid,
    input  logic         in_last,
    input  dp_cmd_t      cmd,
    output dp_stat_t     stat,
    input  logic         out_ready,
    output logic         out_valid,
    output logic [71:0]  out_data,
    output logic         out_last
);

    logic [1:0]  dim_reg;
    logic [31:0] gamma_reg, courant_reg, spacing_reg;
    logic [31:0] p_reg, d_reg, vx_reg, vy_reg, vz_reg, sx_reg, sy_reg, sz_reg;
    logic        solid_reg, last_reg;
    logic [63:0] prod_reg;
    logic [95:0] acc_reg;
    logic [63:0] cell_reg, max_reg;
    logic [31:0] dt_reg;
    logic        out_valid_reg;
    logic [71:0] out_data_reg;

    logic [DIV_STEPS-1:0] dvd_reg;
    logic [63:0]          rem_reg, quo_reg, den_reg;
    logic                 dsat_reg, dbusy_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;

    logic [63:0]           sv_reg, sres_reg, sbit_reg;
    logic                  sbusy_reg;
    logic [SQRT_CNT_W-1:0] scnt_reg;

    logic [31:0] mul_a, mul_b;
    logic [63:0] div_num, div_den, div_res;
    logic [DIV_STEPS-1:0] dvd_init;
    logic        div_start;
    logic [64:0] rem_trial, sq_trial;
    logic        rem_ge, sq_ge;
    logic        snd_ovf;
    logic [31:0] snd;

    function automatic logic [63:0] mag32(input logic [31:0] v);
        logic [32:0] m;
        m = v[31] ? (33'h1_0000_0000 - {1'b0, v}) : {1'b0, v};
        return {31'b0, m};
    endfunction

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_reg     <= DIM_RESET;
            gamma_reg   <= GAMMA_RESET;
            courant_reg <= COURANT_RESET;
            spacing_reg <= SPACING_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_DIM:     dim_reg     <= cfg_data[1:0];
                REG_GAMMA:   gamma_reg   <= cfg_data;
                REG_COURANT: courant_reg <= cfg_data;
                REG_SPACING: spacing_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Operand capture, multiplier and spacing product.
    always_comb
    begin
        case (cmd.op)
            OP_MUL_LO: begin mul_a = max_reg[31:0];  mul_b = spacing_reg; end
            OP_MUL_HI: begin mul_a = max_reg[63:32]; mul_b = spacing_reg; end
            default:   begin mul_a = gamma_reg;      mul_b = p_reg;       end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == OP_LOAD)
        begin
            p_reg     <= in_data[31:0];
            d_reg     <= in_data[63:32];
            vx_reg    <= in_data[95:64];
            vy_reg    <= in_data[127:96];
            vz_reg    <= in_data[159:128];
            sx_reg    <= in_data[191:160];
            sy_reg    <= in_data[223:192];
            sz_reg    <= in_data[255:224];
            solid_reg <= in_solid;
            last_reg  <= in_last;
        end
        if (cmd.op == OP_MUL_GP || cmd.op == OP_MUL_LO || cmd.op == OP_MUL_HI)
            prod_reg <= 64'(mul_a * mul_b);
        if (cmd.op == OP_MUL_HI)
            acc_reg <= {32'b0, prod_reg};
        else if (cmd.op == OP_ACC)
            acc_reg <= acc_reg + {prod_reg, 32'b0};
    end

    // Restoring divider, one quotient bit per cycle over a dividend shifted
    // left by F or 2F; quotient bits above bit 63 saturate the result.
    always_comb
    begin
        case (cmd.op)
            OP_DIV_C2: begin div_num = prod_reg;             div_den = {32'b0, d_reg};  end
            OP_DIV_R:  begin div_num = sres_reg;             div_den = {32'b0, sx_reg}; end
            OP_DIV_VX: begin div_num = mag32(vx_reg);        div_den = {32'b0, sx_reg}; end
            OP_DIV_VY: begin div_num = mag32(vy_reg);        div_den = {32'b0, sy_reg}; end
            OP_DIV_VZ: begin div_num = mag32(vz_reg);        div_den = {32'b0, sz_reg}; end
            default:   begin div_num = {32'b0, courant_reg}; div_den = max_reg;         end
        endcase
        if (cmd.op == OP_DIV_C2)
            dvd_init = DIV_STEPS'(div_num) << FRAC_BITS;
        else
            dvd_init = DIV_STEPS'(div_num) << RATE_SH;
        div_start = cmd.start && (cmd.op == OP_DIV_C2 || cmd.op == OP_DIV_R ||
                    cmd.op == OP_DIV_VX || cmd.op == OP_DIV_VY ||
                    cmd.op == OP_DIV_VZ || cmd.op == OP_DIV_DT);
        rem_trial = {rem_reg, dvd_reg[DIV_STEPS-1]};
        rem_ge    = rem_trial >= {1'b0, den_reg};
        div_res   = dsat_reg ? '1 : quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dbusy_reg <= 1'b0;
        else if (div_start)
            dbusy_reg <= 1'b1;
        else if (dbusy_reg && dcnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            dbusy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (div_start)
        begin
            dvd_reg  <= dvd_init;
            den_reg  <= div_den;
            rem_reg  <= '0;
            quo_reg  <= '0;
            dsat_reg <= 1'b0;
            dcnt_reg <= '0;
        end
        else if (dbusy_reg)
        begin
            dvd_reg  <= dvd_reg << 1;
            rem_reg  <= rem_ge ? 64'(rem_trial - {1'b0, den_reg}) : rem_trial[63:0];
            quo_reg  <= {quo_reg[62:0], rem_ge};
            dsat_reg <= dsat_reg | (rem_ge && dcnt_reg < DIV_CNT_W'(DIV_STEPS - 64));
            dcnt_reg <= dcnt_reg + 1'b1;
        end
    end

    // Square-root unit, one result bit per cycle.
    always_comb
    begin
        sq_trial = {1'b0, sres_reg} + {1'b0, sbit_reg};
        sq_ge    = {1'b0, sv_reg} >= sq_trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            sbusy_reg <= 1'b0;
        else if (cmd.start && cmd.op == OP_SQRT)
            sbusy_reg <= 1'b1;
        else if (sbusy_reg && scnt_reg == SQRT_CNT_W'(SQRT_STEPS - 1))
            sbusy_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start && cmd.op == OP_SQRT)
        begin
            sv_reg   <= div_res;
            sres_reg <= '0;
            sbit_reg <= 64'd1 << 62;
            scnt_reg <= '0;
        end
        else if (sbusy_reg)
        begin
            if (sq_ge)
            begin
                sv_reg   <= sv_reg - sq_trial[63:0];
                sres_reg <= (sres_reg >> 1) + sbit_reg;
            end
            else
                sres_reg <= sres_reg >> 1;
            sbit_reg <= sbit_reg >> 2;
            scnt_reg <= scnt_reg + 1'b1;
        end
    end

    // Cell rate, running maximum and result register.
    always_comb
    begin
        snd_ovf = |acc_reg[95:32+RATE_SH];
        snd     = snd_ovf ? '1 : acc_reg[32+RATE_SH-1:RATE_SH];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take && cmd.op == OP_DIV_R)
            cell_reg <= div_res;
        else if (cmd.take && (cmd.op == OP_DIV_VX || cmd.op == OP_DIV_VY ||
                 cmd.op == OP_DIV_VZ) && div_res > cell_reg)
            cell_reg <= div_res;
        if (cmd.take && cmd.op == OP_DIV_DT)
            dt_reg <= (|div_res[63:32]) ? '1 : div_res[31:0];
        if (cmd.op == OP_RESULT)
            out_data_reg <= {7'b0, dt_reg == 32'd0, snd, dt_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.op == OP_UPDATE && cell_reg > max_reg)
                max_reg <= cell_reg;
            else if (cmd.op == OP_RESULT)
                max_reg <= '0;
            if (cmd.op == OP_RESULT)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    assign stat.fluid     = !solid_reg && dim_reg != 2'd0;
    assign stat.last      = last_reg;
    assign stat.dim       = dim_reg;
    assign stat.div_busy  = dbusy_reg;
    assign stat.sqrt_busy = sbusy_reg;
    assign stat.out_full  = out_valid_reg;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_last  = 1'b1;

endmodule

// ===== hdl/cflts_ctrl.sv =====
// Sequencing state machine of the CFL time-step reduction.
// Drives datapath commands from datapath status; depends on cflts_pkg.
module cflts_ctrl
    import cflts_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE, S_CHK, S_MUL, S_C2, S_SQRT, S_R, S_VX, S_VY, S_VZ,
        S_UPD, S_DT, S_MLO, S_MHI, S_ACC, S_OUT
    } state_t;

    state_t state_reg;
    logic   go_reg;
    logic   unit_busy;

    always_comb
    begin
        unit_busy = (state_reg == S_SQRT) ? stat.sqrt_busy : stat.div_busy;
        in_ready  = 1'b0;
        cmd.op    = OP_NONE;
        cmd.start = !go_reg;
        cmd.take  = go_reg && !unit_busy;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                    cmd.op = OP_LOAD;
            end
            S_MUL:  cmd.op = OP_MUL_GP;
            S_C2:   cmd.op = OP_DIV_C2;
            S_SQRT: cmd.op = OP_SQRT;
            S_R:    cmd.op = OP_DIV_R;
            S_VX:   cmd.op = OP_DIV_VX;
            S_VY:   cmd.op = OP_DIV_VY;
            S_VZ:   cmd.op = OP_DIV_VZ;
            S_UPD:  cmd.op = OP_UPDATE;
            S_DT:   cmd.op = OP_DIV_DT;
            S_MLO:  cmd.op = OP_MUL_LO;
            S_MHI:  cmd.op = OP_MUL_HI;
            S_ACC:  cmd.op = OP_ACC;
            S_OUT:
            begin
                if (!stat.out_full)
                    cmd.op = OP_RESULT;
            end
            default: cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            go_reg    <= 1'b0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                        state_reg <= S_CHK;
                end
                S_CHK:
                begin
                    if (stat.fluid)
                        state_reg <= S_MUL;
                    else if (stat.last)
                        state_reg <= S_DT;
                    else
                        state_reg <= S_IDLE;
                end
                S_MUL: state_reg <= S_C2;
                S_C2, S_SQRT, S_R, S_VX, S_VY, S_VZ, S_DT:
                begin
                    if (!go_reg)
                        go_reg <= 1'b1;
                    else if (!unit_busy)
                    begin
                        go_reg <= 1'b0;
                        case (state_reg)
                            S_C2:   state_reg <= S_SQRT;
                            S_SQRT: state_reg <= S_R;
                            S_R:    state_reg <= S_VX;
                            S_VX:   state_reg <= (stat.dim >= 2'd2) ? S_VY : S_UPD;
                            S_VY:   state_reg <= (stat.dim == 2'd3) ? S_VZ : S_UPD;
                            S_VZ:   state_reg <= S_UPD;
                            default: state_reg <= S_MLO;
                        endcase
                    end
                end
                S_UPD: state_reg <= stat.last ? S_DT : S_IDLE;
                S_MLO: state_reg <= S_MHI;
                S_MHI: state_reg <= S_ACC;
                S_ACC: state_reg <= S_OUT;
                S_OUT:
                begin
                    if (!stat.out_full)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/cfl_time_step_reduction.sv =====
// Top level of the CFL time-step reduction block.
// Joins cflts_ctrl and cflts_dp; depends on cflts_pkg.
//
//  Channel   Direction  Handshake          Content
//  s_*       in         s_tvalid/s_tready  one grid cell per transaction
//  m_*       out        m_tvalid/m_tready  one result per sweep
//  cfg_*     in         cfg_we             register write, no read-back
//
// A solid cell (or any cell with a dimension count of zero) computes no rate.
// A fluid cell's time is set by the single shared 96-step restoring divider
// and the 32-step root, and shrinks with each inactive axis.
// The last cell of a sweep adds a further divide and the two-part spacing
// product. Reset clears all control state and loads the configuration
// defaults. The finished result waits in an output register, so a stalled
// consumer holds up the input only when a second result is due.
module cfl_time_step_reduction
    import cflts_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pressure, density, vel_x, vel_y, vel_z, size_x, size_y, size_z (32 each)
    input  logic [255:0] s_tdata,
    // solid_cell
    input  logic         s_tuser,
    input  logic         s_tlast,
    output logic         m_tvalid,
    input  logic         m_tready,
    // time_step[31:0], initial_sound_speed[63:32], zero_step_error[64], zeros
    output logic [71:0]  m_tdata,
    output logic         m_tlast,
    input  logic         cfg_we,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    dp_cmd_t  cmd;
    dp_stat_t stat;

    // The controller walks each cell through the shared units in turn.
    cflts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds operands, the running maximum and the result.
    cflts_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (s_tdata),
        .in_solid  (s_tuser),
        .in_last   (s_tlast),
        .cmd       (cmd),
        .stat      (stat),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

endmodule

// ===== hdl/cflts_chk.sv =====
// Port-level checks for the CFL time-step reduction block.
// Bound to cfl_time_step_reduction; depends on nothing else.
module cflts_chk
(
    input logic         clk,
    input logic         rst_n,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [71:0]  m_tdata,
    input logic         m_tlast
);

    // A stalled result stays offered.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped while stalled");

    // Every result closes a sweep.
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tlast)
        else $error("result without tlast");

    // The error flag matches a zero time step.
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[64] == (m_tdata[31:0] == 32'd0)))
        else $error("zero-step flag inconsistent");

    // Padding bits stay clear.
    a_pad: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[71:65] == 7'd0)
        else $error("padding bits set");

endmodule

bind cfl_time_step_reduction cflts_chk u_chk (.*);

// ===== sim/cfl_time_step_reduction_tb.sv =====
// Self-checking testbench for cfl_time_step_reduction: drives grid cells,
// predicts the per-sweep time step in fixed point and checks every result.
// Depends on cflts_pkg and the RTL of the block; nothing else.
`timescale 1ns / 100ps

module cfl_time_step_reduction_tb
    import cflts_pkg::*;
();

    // One grid cell as the block sees it on the input stream.
    typedef struct packed {
        logic        solid;
        logic        last;
        logic [31:0] pressure;
        logic [31:0] density;
        logic [31:0] vel_x;
        logic [31:0] vel_y;
        logic [31:0] vel_z;
        logic [31:0] size_x;
        logic [31:0] size_y;
        logic [31:0] size_z;
    } cell_t;

    // One sweep result.
    typedef struct packed {
        logic [31:0] time_step;
        logic [31:0] sound_speed;
        logic        zero_step;
    } sweep_result_t;

    localparam int HALF_PERIOD   = 5;
    localparam int SETTLE_CYCLES = 700;   // longer than a fluid cell plus a last cell
    localparam int STALL_CYCLES  = 3000;  // the long receiver hold-off
    localparam int WATCHDOG_MAX  = 20000;
    localparam int QUIET_FROM    = 100000;
    localparam int QUIET_TO      = 160000;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [255:0] s_tdata   = '0;
    logic         s_tuser   = 1'b0;
    logic         s_tlast   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [71:0]  m_tdata;
    logic         m_tlast;
    logic         cfg_we    = 1'b0;
    logic [1:0]   cfg_index = REG_DIM;
    logic [31:0]  cfg_data  = '0;

    cfl_time_step_reduction dut (.*);

    always #HALF_PERIOD clk = ~clk;

    // Predictor state: its own copy of the registers and the running maximum.
    logic [1:0]  axes_model    = DIM_RESET;
    logic [31:0] gamma_model   = GAMMA_RESET;
    logic [31:0] courant_model = COURANT_RESET;
    logic [31:0] spacing_model = SPACING_RESET;
    logic [63:0] peak_rate     = '0;

    cell_t         cells_pending[$];
    sweep_result_t sweeps_expected[$];
    int            errors = 0;
    int            cyc = 0;
    int            idle_count = 0;
    logic          stall_req = 1'b0;
    cell_t         cell_on_bus;

    // floor(num * 2^sh / den), saturated to 64 bits; a zero divisor gives all ones.
    function automatic logic [63:0] div_sat(logic [63:0] num, int sh, logic [63:0] den);
        logic [127:0] q;
        if (den == 0)
            return '1;
        q = ({64'd0, num} << sh) / {64'd0, den};
        return (q[127:64] != 0) ? '1 : q[63:0];
    endfunction

    function automatic logic [63:0] int_sqrt(logic [63:0] v);
        logic [63:0] res;
        logic [63:0] bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // |vel| / size as a Q.2F rate; the most negative velocity has magnitude 2^31.
    function automatic logic [63:0] axis_rate(logic [31:0] vel, logic [31:0] size);
        logic [63:0] mag;
        mag = vel[31] ? (64'h1_0000_0000 - {32'd0, vel}) : {32'd0, vel};
        return div_sat(mag, RATE_SH, {32'd0, size});
    endfunction

    // Folds one accepted cell into the running maximum and, on the last cell
    // of a sweep, queues the time step and sound speed the block must report.
    task automatic absorb_cell(cell_t c);
        logic [63:0]  prod, rate, v, dt;
        logic [127:0] wide;
        sweep_result_t r;
        if (!c.solid && axes_model != 0)
        begin
            prod = {32'd0, gamma_model} * {32'd0, c.pressure};
            rate = div_sat(int_sqrt(div_sat(prod, FRAC_BITS, {32'd0, c.density})),
                           RATE_SH, {32'd0, c.size_x});
            v = axis_rate(c.vel_x, c.size_x);
            if (v > rate) rate = v;
            if (axes_model >= 2)
            begin
                v = axis_rate(c.vel_y, c.size_y);
                if (v > rate) rate = v;
            end
            if (axes_model >= 3)
            begin
                v = axis_rate(c.vel_z, c.size_z);
                if (v > rate) rate = v;
            end
            if (rate > peak_rate)
                peak_rate = rate;
        end
        if (c.last)
        begin
            if (peak_rate == 0)
                dt = 64'hFFFF_FFFF;
            else
            begin
                dt = div_sat({32'd0, courant_model}, RATE_SH, peak_rate);
                if (dt > 64'hFFFF_FFFF) dt = 64'hFFFF_FFFF;
            end
            wide = {64'd0, peak_rate} * {96'd0, spacing_model};
            wide = wide >> RATE_SH;
            r.time_step   = dt[31:0];
            r.sound_speed = (wide > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : wide[31:0];
            r.zero_step   = (dt == 0);
            sweeps_expected.push_back(r);
            peak_rate = '0;
        end
    endtask

    function automatic bit quiet();
        return cyc >= QUIET_FROM && cyc < QUIET_TO;
    endfunction

    // Driver: predicts each accepted transaction, then offers the next cell.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            logic  offer;
            cell_t nxt;
            offer = s_tvalid;
            nxt   = cell_on_bus;
            if (s_tvalid && s_tready)
            begin
                absorb_cell(cell_on_bus);
                offer = 1'b0;
            end
            if (!offer && cells_pending.size() > 0 && (quiet() || $urandom_range(0, 99) >= 21))
            begin
                nxt   = cells_pending.pop_front();
                offer = 1'b1;
            end
            cell_on_bus = nxt;
            s_tvalid <= offer;
            s_tdata  <= {nxt.size_z, nxt.size_y, nxt.size_x, nxt.vel_z, nxt.vel_y,
                         nxt.vel_x, nxt.density, nxt.pressure};
            s_tuser  <= nxt.solid;
            s_tlast  <= nxt.last;
        end
    end

    // Monitor: random back-pressure, one long hold-off on request, and the checks.
    always @(posedge clk or negedge rst_n)
    begin
        static int hold_left = 0;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            sweep_result_t e;
            if (m_tvalid && m_tready)
            begin
                if (sweeps_expected.size() == 0)
                begin
                    $error("unexpected result transaction: data %h", m_tdata);
                    errors++;
                end
                else
                begin
                    e = sweeps_expected.pop_front();
                    if (m_tdata[31:0] !== e.time_step)
                    begin
                        $error("time_step: expected %h, actual %h", e.time_step, m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[63:32] !== e.sound_speed)
                    begin
                        $error("initial_sound_speed: expected %h, actual %h",
                               e.sound_speed, m_tdata[63:32]);
                        errors++;
                    end
                    if (m_tdata[64] !== e.zero_step)
                    begin
                        $error("zero_step_error: expected %b, actual %b", e.zero_step, m_tdata[64]);
                        errors++;
                    end
                    if (m_tlast !== 1'b1)
                    begin
                        $error("last_result: expected 1, actual %b", m_tlast);
                        errors++;
                    end
                end
            end
            if (stall_req)
                hold_left = STALL_CYCLES;
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= quiet() || $urandom_range(0, 99) >= 21;
        end
    end

    // Watchdog: too long without any transaction on either stream ends the run.
    always @(posedge clk)
    begin
        cyc++;
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_count = 0;
        else if (++idle_count >= WATCHDOG_MAX)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // A value drawn from one of several ranges so that both tiny and huge
    // rates appear, with every bit of the word still reachable.
    function automatic logic [31:0] pick_word(bit nonzero);
        logic [31:0] w;
        case ($urandom_range(0, 4))
            0: w = $urandom;
            1: w = $urandom_range(1, 32'h0010_0000);
            2: w = $urandom_range(32'h0000_4000, 32'h0004_0000);
            3: w = $urandom_range(1, 255);
            default: w = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd1;
        endcase
        if (nonzero && w == 0)
            w = 1;
        return w;
    endfunction

    function automatic logic [31:0] pick_velocity();
        logic [31:0] w;
        w = pick_word(1'b0);
        return $urandom_range(0, 1) ? (~w + 1) : w;
    endfunction

    function automatic cell_t random_cell(bit last);
        cell_t c;
        c.solid    = ($urandom_range(0, 99) < 20);
        c.last     = last;
        c.pressure = pick_word(1'b0);
        c.density  = pick_word(1'b1);
        c.vel_x    = pick_velocity();
        c.vel_y    = pick_velocity();
        c.vel_z    = pick_velocity();
        c.size_x   = pick_word(1'b1);
        c.size_y   = pick_word(1'b1);
        c.size_z   = pick_word(1'b1);
        return c;
    endfunction

    function automatic cell_t fluid_cell(logic [31:0] p, logic [31:0] rho, logic [31:0] v,
                                         logic [31:0] sz, bit last);
        cell_t c;
        c = '{solid: 1'b0, last: last, pressure: p, density: rho, vel_x: v, vel_y: v,
              vel_z: v, size_x: sz, size_y: sz, size_z: sz};
        return c;
    endfunction

    task automatic write_reg(logic [1:0] idx, logic [31:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        case (idx)
            REG_DIM:     axes_model    = value[1:0];
            REG_GAMMA:   gamma_model   = value;
            REG_COURANT: courant_model = value;
            default:     spacing_model = value;
        endcase
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Waits until every cell has been taken and every result checked, then
    // lets a cell that causes no result finish before the registers change.
    task automatic wait_idle();
        while (cells_pending.size() != 0 || s_tvalid || sweeps_expected.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Random sweeps of 1 to 12 cells, each closed by a last cell, until
    // at least count cells have been queued.
    task automatic random_sweeps(int count);
        int n, len;
        n = 0;
        while (n < count)
        begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++)
                cells_pending.push_back(random_cell(k == len - 1));
            n += len;
        end
    endtask

    initial
    begin
        cell_t c;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // Directed sweeps with the reset settings: extremes of every field.
        cells_pending.push_back(fluid_cell(0, 1, 32'h8000_0000, 1, 1'b1));
        cells_pending.push_back(fluid_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                           32'hFFFF_FFFF, 1'b1));
        cells_pending.push_back(fluid_cell(32'hFFFF_FFFF, 1, 0, 1, 1'b1));
        cells_pending.push_back(fluid_cell(0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1'b1));
        cells_pending.push_back(fluid_cell(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000,
                                           32'h0001_0000, 1'b0));
        cells_pending.push_back(fluid_cell(32'h0004_0000, 32'h0002_0000, 32'h0003_0000,
                                           32'h0000_8000, 1'b1));
        // A solid last cell still closes the sweep; a lone last cell reports a zero maximum.
        c = fluid_cell(32'hFFFF_FFFF, 1, 32'h7FFF_FFFF, 1, 1'b1);
        c.solid = 1'b1;
        cells_pending.push_back(fluid_cell(32'h0002_0000, 32'h0001_0000, 32'h0001_0000,
                                           32'h0001_0000, 1'b0));
        cells_pending.push_back(c);
        cells_pending.push_back(c);
        c = fluid_cell(32'h0001_0000, 32'h0001_0000, 32'h0000_1000, 32'h0010_0000, 1'b0);
        c.vel_y = 32'h8000_0000;
        c.vel_z = 32'h7FFF_FFFF;
        c.size_z = 1;
        cells_pending.push_back(c);
        cells_pending.push_back(fluid_cell(0, 1, 0, 1, 1'b1));
        random_sweeps(120);
        wait_idle();

        // Long receiver hold-off while sweeps of solid cells keep arriving, so
        // the result register fills and the input stream backs up.
        @(posedge clk);
        stall_req <= 1'b1;
        @(posedge clk);
        stall_req <= 1'b0;
        for (int k = 0; k < 10; k++)
        begin
            c = random_cell(1'b1);
            c.solid = 1'b1;
            cells_pending.push_back(c);
        end
        wait_idle();

        // One axis, zero adiabatic index, largest Courant factor and spacing.
        write_reg(REG_DIM, 32'd1);
        write_reg(REG_GAMMA, 32'd0);
        write_reg(REG_COURANT, 32'hFFFF_FFFF);
        write_reg(REG_SPACING, 32'hFFFF_FFFF);
        random_sweeps(140);
        wait_idle();

        // Two axes, largest index, zero Courant factor (zero time step) and spacing.
        write_reg(REG_DIM, 32'd2);
        write_reg(REG_GAMMA, 32'hFFFF_FFFF);
        write_reg(REG_COURANT, 32'd0);
        write_reg(REG_SPACING, 32'd0);
        random_sweeps(140);
        wait_idle();

        // No active axis: fluid cells add nothing to the maximum.
        write_reg(REG_DIM, 32'd0);
        write_reg(REG_COURANT, 32'd1);
        random_sweeps(60);
        wait_idle();

        // Three axes with random settings.
        write_reg(REG_DIM, 32'd3);
        write_reg(REG_GAMMA, $urandom_range(32'h0001_0000, 32'h0003_0000));
        write_reg(REG_COURANT, $urandom);
        write_reg(REG_SPACING, $urandom_range(1, 32'h0010_0000));
        random_sweeps(220);
        wait_idle();

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
